// File: src/mqof_pkg.sv
// ----------------------------------------------------------------------------
// mqof_pkg
// Shared types and constants for the multi-queue overwrite FIFO: field widths,
// action and status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mqof_pkg;

  // Default configuration
  localparam int unsigned NumQueuesDef  = 8;
  localparam int unsigned QueueDepthDef = 16;

  // Fixed field widths
  localparam int unsigned HandleW  = 4;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned ActionW  = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned InDataW  = 40;  // handle, write_value, zero fill
  localparam int unsigned OutDataW = 40;  // new_handle, read_value, dropped_oldest

  typedef enum logic [ActionW-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NO_FREE    = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_RESP
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // latch request, start pointer lookup
    logic exec;     // apply operation to pointers and store
    logic load;     // move result into output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free; // output register empty or draining this cycle
  } dp_status_t;

endpackage : mqof_pkg

`default_nettype wire

// File: src/mqof_ctrl.sv
// ----------------------------------------------------------------------------
// mqof_ctrl
// Request sequencer: accept, execute against pointer table and store, then
// hand the result to the output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mqof_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mqof_pkg::dp_status_t dp_status_i,
  output mqof_pkg::ctrl_cmd_t     cmd_o
);
  import mqof_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_EXEC;
      end
      CS_EXEC: begin
        state_d = CS_RESP;
      end
      CS_RESP: begin
        if (dp_status_i.out_free) state_d = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      CS_RESP: begin
        cmd_o.load = dp_status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule : mqof_ctrl

`default_nettype wire

// File: src/mqof_dp.sv
// ----------------------------------------------------------------------------
// mqof_dp
// Datapath: request registers, per-queue pointer table, shared entry store,
// allocation counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqof_dp #(
  parameter int unsigned NUM_QUEUES  = mqof_pkg::NumQueuesDef,
  parameter int unsigned QUEUE_DEPTH = mqof_pkg::QueueDepthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mqof_pkg::ctrl_cmd_t              cmd_i,
  output mqof_pkg::dp_status_t                  status_o,
  input  wire logic [mqof_pkg::ActionW-1:0]     in_action_i,
  input  wire logic [mqof_pkg::HandleW-1:0]     in_handle_i,
  input  wire logic [mqof_pkg::ValueW-1:0]      in_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [mqof_pkg::StatusW-1:0]          out_status_o,
  output logic [mqof_pkg::OutDataW-1:0]         out_data_o
);
  import mqof_pkg::*;

  localparam int unsigned QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned CW  = $clog2(NUM_QUEUES + 1);
  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SD  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AW  = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned VW  = (CW > HandleW) ? CW : HandleW;
  localparam int unsigned PadW = OutDataW - HandleW - ValueW - 1;

  // Request registers
  logic [ActionW-1:0] action_q;
  logic [HandleW-1:0] handle_q;
  logic [ValueW-1:0]  value_q;

  // Number of claimed queues; queues are claimed in order and never released
  logic [CW-1:0] alloc_cnt_q;

  // Pointer table
  logic [PW-1:0] head_mem [NUM_QUEUES];
  logic [FW-1:0] fill_mem [NUM_QUEUES];
  logic [PW-1:0] head_rd_q;
  logic [FW-1:0] fill_rd_q;
  logic          ptr_we;
  logic [QIW-1:0] ptr_waddr;
  logic [PW-1:0] head_wr;
  logic [FW-1:0] fill_wr;

  // Entry store
  logic [ValueW-1:0] store_mem [SD];
  logic [ValueW-1:0] store_rd_q;
  logic              store_we;
  logic              store_re;
  logic [AW-1:0]     store_addr;

  // Result registers
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [HandleW-1:0] res_handle_q, res_handle_d;
  logic               res_drop_q,   res_drop_d;
  logic               res_rdok_q,   res_rdok_d;
  logic [CW-1:0]      alloc_cnt_d;

  // Output register
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [OutDataW-1:0] out_data_q;

  // Queue index from handle (handle - 1)
  logic [HandleW-1:0]     hm1_in, hm1_q;
  logic [HandleW+QIW-1:0] hext_in, hext_q, cext;
  logic [QIW-1:0]         qidx_in, qidx_q, qidx_alloc;

  assign hm1_in     = in_handle_i - HandleW'(1);
  assign hm1_q      = handle_q - HandleW'(1);
  assign hext_in    = {{QIW{1'b0}}, hm1_in};
  assign hext_q     = {{QIW{1'b0}}, hm1_q};
  assign cext       = (HandleW + QIW)'(alloc_cnt_q);
  assign qidx_in    = hext_in[QIW-1:0];
  assign qidx_q     = hext_q[QIW-1:0];
  assign qidx_alloc = cext[QIW-1:0];

  // Execution-stage arithmetic
  logic           handle_ok;
  logic           q_full, q_empty;
  logic [FW:0]    pos_sum;
  logic [FW:0]    pos_wrap;
  logic [PW-1:0]  tail_pos;
  logic [PW-1:0]  head_inc;
  logic [AW:0]    base_prod;
  logic [AW-1:0]  base_addr;
  logic [CW:0]    new_handle_full;
  logic [CW+HandleW-1:0] new_handle_ext;

  assign handle_ok = (handle_q != '0) && (VW'(handle_q) <= VW'(alloc_cnt_q));
  assign q_full    = (fill_rd_q == FW'(QUEUE_DEPTH));
  assign q_empty   = (fill_rd_q == '0);
  assign pos_sum   = (FW + 1)'(head_rd_q) + (FW + 1)'(fill_rd_q);
  // head < depth and fill <= depth, so one subtract wraps the tail
  assign pos_wrap  = (pos_sum >= (FW + 1)'(QUEUE_DEPTH))
                     ? pos_sum - (FW + 1)'(QUEUE_DEPTH) : pos_sum;
  assign tail_pos  = pos_wrap[PW-1:0];
  assign head_inc  = (head_rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_rd_q + PW'(1);
  assign base_prod = (AW + 1)'(qidx_q) * (AW + 1)'(QUEUE_DEPTH);
  assign base_addr = base_prod[AW-1:0];
  assign new_handle_full = (CW + 1)'(alloc_cnt_q) + (CW + 1)'(1);
  assign new_handle_ext  = (CW + HandleW)'(new_handle_full);

  always_comb begin
    res_status_d = ST_OK;
    res_handle_d = '0;
    res_drop_d   = 1'b0;
    res_rdok_d   = 1'b0;
    alloc_cnt_d  = alloc_cnt_q;
    ptr_we       = 1'b0;
    ptr_waddr    = qidx_q;
    head_wr      = head_rd_q;
    fill_wr      = fill_rd_q;
    store_we     = 1'b0;
    store_re     = 1'b0;
    store_addr   = base_addr + AW'(tail_pos);
    unique case (action_q)
      ACT_ALLOC: begin
        if (alloc_cnt_q < CW'(NUM_QUEUES)) begin
          ptr_we       = cmd_i.exec;
          ptr_waddr    = qidx_alloc;
          head_wr      = '0;
          fill_wr      = '0;
          alloc_cnt_d  = alloc_cnt_q + CW'(1);
          res_handle_d = new_handle_ext[HandleW-1:0];
        end else begin
          res_status_d = ST_NO_FREE;
        end
      end
      ACT_WRITE: begin
        if (handle_ok) begin
          ptr_we   = cmd_i.exec;
          store_we = cmd_i.exec;
          if (q_full) begin
            // overwrite the oldest and advance past it
            head_wr    = head_inc;
            res_drop_d = 1'b1;
          end else begin
            fill_wr = fill_rd_q + FW'(1);
          end
        end else begin
          res_status_d = ST_BAD_HANDLE;
        end
      end
      ACT_READ: begin
        store_addr = base_addr + AW'(head_rd_q);
        if (!handle_ok) begin
          res_status_d = ST_BAD_HANDLE;
        end else if (q_empty) begin
          res_status_d = ST_EMPTY;
        end else begin
          ptr_we     = cmd_i.exec;
          store_re   = cmd_i.exec;
          head_wr    = head_inc;
          fill_wr    = fill_rd_q - FW'(1);
          res_rdok_d = 1'b1;
        end
      end
      default: begin
        res_status_d = ST_BAD_HANDLE;
      end
    endcase
  end

  // Pointer table: read on accept, write on execute
  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      head_mem[ptr_waddr] <= head_wr;
      fill_mem[ptr_waddr] <= fill_wr;
    end
    if (cmd_i.accept) begin
      head_rd_q <= head_mem[qidx_in];
      fill_rd_q <= fill_mem[qidx_in];
    end
  end

  // Entry store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_addr] <= value_q;
    end
    if (store_re) begin
      store_rd_q <= store_mem[store_addr];
    end
  end

  // Request and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= in_action_i;
      handle_q <= in_handle_i;
      value_q  <= in_value_i;
    end
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      res_handle_q <= res_handle_d;
      res_drop_q   <= res_drop_d;
      res_rdok_q   <= res_rdok_d;
    end
    if (cmd_i.load) begin
      out_status_q <= res_status_q;
      out_data_q   <= {{PadW{1'b0}}, res_drop_q,
                       (res_rdok_q ? store_rd_q : '0), res_handle_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        alloc_cnt_q <= alloc_cnt_d;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;

endmodule : mqof_dp

`default_nettype wire

// File: src/multi_queue_overwrite_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_overwrite_fifo
// Bank of ring-buffer queues over one shared entry store. Allocate claims the
// lowest free queue; write appends and overwrites the oldest when full; read
// pops the oldest entry.
//
//   Channel  Dir  tdata (low bit up)                         tuser
//   s_axis   in   handle[3:0], write_value[35:4], zero fill  action[1:0]
//   m_axis   out  new_handle[3:0], read_value[35:4],         status[1:0]
//                 dropped_oldest[36], zero fill
//
// Each request goes through accept with pointer-table read, execute with
// the store access, then transfer into the output register.
// One request is in flight at a time; the next is taken while a result waits.
// A stalled output holds the result and delays only the load step.
// Reset clears the claim count and output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_overwrite_fifo #(
  parameter int unsigned NUM_QUEUES  = mqof_pkg::NumQueuesDef,
  parameter int unsigned QUEUE_DEPTH = mqof_pkg::QueueDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [mqof_pkg::InDataW-1:0]  s_axis_tdata,  // handle, write_value
  input  wire logic [mqof_pkg::ActionW-1:0]  s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [mqof_pkg::OutDataW-1:0]      m_axis_tdata,  // new_handle, read_value,
                                                            // dropped_oldest
  output logic [mqof_pkg::StatusW-1:0]       m_axis_tuser   // status
);
  import mqof_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  mqof_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  mqof_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .in_action_i  (s_axis_tuser),
    .in_handle_i  (s_axis_tdata[HandleW-1:0]),
    .in_value_i   (s_axis_tdata[HandleW+ValueW-1:HandleW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule : multi_queue_overwrite_fifo

`default_nettype wire
